// File: hdl/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define CHK_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hdl/wrhf_pkg.sv
// Package for the water ripple height field unit
package wrhf_pkg;
    localparam int FieldWidthDef  = 256;
    localparam int FieldHeightDef = 256;
    localparam int LensUnit       = 1024;
    localparam logic [1:0] MODE_DROP = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_MAP  = 2'd2;
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_DAMP   = 2'd2;
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DROP_RD, ST_DROP_WR, ST_STEP_RD, ST_STEP_WR,
        ST_MAP_RD, ST_MAP_MUL, ST_MAP_CLAMP, ST_OUT
    } state_t;
endpackage

// File: hdl/water_ripple_height_field_unit.sv
// Water ripple height field unit: two-buffer wave field, drops, lens mapping
// One transaction is worked at a time. The input is not ready again until the result has been
// taken. Each transaction is accepted in the idle state, worked, then held in the output state.
// The work depends on the mode:
// - A drop reads each cell of the 2r x 2r square around its center and writes those inside r.
// - A drop rejected at an edge, a zero radius or the unused mode does no work.
// - A frame step does five reads and one write per cell through the single memory port, over every
//   cell of rows 1 to H-2.
// - A pixel map reads the cell, then multiplies and clamps for x and then for y.
// Cells sit at address row*2^clog2(W) + column. After reset a clearing pass zeroes both fields
// before the first transaction is taken. It clears all 2^(clog2(W)+clog2(H)) memory words,
// which is W*H for power-of-two sizes.
module water_ripple_height_field_unit #(
    parameter int FIELD_WIDTH  = wrhf_pkg::FieldWidthDef,
    parameter int FIELD_HEIGHT = wrhf_pkg::FieldHeightDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pos_x[7:0], pos_y[15:8]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // src_x[7:0], src_y[15:8], accepted[16], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int XW = $clog2(FIELD_WIDTH);
    localparam int YW = $clog2(FIELD_HEIGHT);
    localparam int AW = XW + YW;
    localparam int CW = 12;
    localparam int DW = 2 * CW + 1;
    localparam logic [XW-1:0] COL_LAST = XW'(FIELD_WIDTH - 1);

    logic [15:0] mem_a [2**AW];
    logic [15:0] mem_b [2**AW];

    wrhf_pkg::state_t state_reg, state_next;
    logic [5:0]  radius_reg;
    logic [15:0] weight_reg;
    logic [3:0]  damp_reg;
    logic        cur_b_reg, cur_b_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]  ph_reg, ph_next;
    logic signed [18:0] sum_reg, sum_next;
    logic [15:0] rd_data;
    logic signed [31:0] prod_reg, prod_next;
    logic [7:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic        acc_reg, acc_next;

    // memory port
    logic          we;
    logic          wr_b;
    logic          rd_b;
    logic          clr_both;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    always_ff @(posedge aclk) begin
        if (we && (wr_b || clr_both)) mem_b[waddr] <= wdata;
        if (we && (!wr_b || clr_both)) mem_a[waddr] <= wdata;
        rd_data <= rd_b ? mem_b[raddr] : mem_a[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wrhf_pkg::ST_CLEAR;
            radius_reg <= 6'd5;
            weight_reg <= 16'd2560;
            damp_reg   <= 4'd5;
            cur_b_reg  <= 1'b0;
            clr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cur_b_reg <= cur_b_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wrhf_pkg::REG_RADIUS: radius_reg <= cfg_data[5:0];
                    wrhf_pkg::REG_WEIGHT: weight_reg <= cfg_data;
                    wrhf_pkg::REG_DAMP:   damp_reg   <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        cx_reg <= cx_next; cy_reg <= cy_next;
        px_reg <= px_next; py_reg <= py_next;
        ph_reg <= ph_next; sum_reg <= sum_next; prod_reg <= prod_next;
        sx_reg <= sx_next; sy_reg <= sy_next; acc_reg <= acc_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == wrhf_pkg::ST_IDLE);
    assign m_tvalid  = (state_reg == wrhf_pkg::ST_OUT);
    assign m_tdata   = {7'd0, acc_reg, sy_reg, sx_reg};

    logic signed [CW-1:0] r_s, dx, dy, in_x, in_y;
    logic signed [DW-1:0] dsq;
    logic signed [CW-1:0] lens_in, half_s, size_s;
    logic signed [15:0]   lens_d;
    logic signed [31:0]   lens_q, lens_a;
    logic signed [18:0]   vv;
    logic signed [15:0]   v16, dmp;
    logic signed [15:0]   hval;
    logic [YW-1:0]        row_c;
    logic [XW-1:0]        col_c;
    logic [AW-1:0]        cell_addr, up_addr, dn_addr, lf_addr, rt_addr;

    always_comb begin
        state_next = state_reg; cur_b_next = cur_b_reg; clr_next = clr_reg;
        cx_next = cx_reg; cy_next = cy_reg;
        px_next = px_reg; py_next = py_reg; ph_next = ph_reg; sum_next = sum_reg;
        prod_next = prod_reg; sx_next = sx_reg; sy_next = sy_reg; acc_next = acc_reg;
        row_c = py_reg[YW-1:0];
        col_c = px_reg[XW-1:0];
        cell_addr = {row_c, col_c};
        up_addr = {row_c - 1'b1, col_c};
        dn_addr = {row_c + 1'b1, col_c};
        lf_addr = (col_c == '0) ? {row_c - 1'b1, COL_LAST} : {row_c, col_c - 1'b1};
        rt_addr = (col_c == COL_LAST) ? {row_c + 1'b1, {XW{1'b0}}} : {row_c, col_c + 1'b1};
        we = 1'b0; clr_both = 1'b0; wr_b = cur_b_reg; rd_b = cur_b_reg;
        waddr = cell_addr;
        raddr = cell_addr; wdata = '0;
        r_s = CW'(radius_reg);
        in_x = CW'(s_tdata[7:0]);
        in_y = CW'(s_tdata[15:8]);
        dx = px_reg - cx_reg; dy = py_reg - cy_reg;
        dsq = DW'(dx) * DW'(dx) + DW'(dy) * DW'(dy) - DW'(r_s) * DW'(r_s);
        vv = (sum_reg >>> 1) - 19'(signed'(rd_data));
        v16 = vv[15:0];
        dmp = v16 >>> damp_reg;
        hval = 16'(wrhf_pkg::LensUnit) - rd_data;
        size_s = (ph_reg[0]) ? CW'(FIELD_HEIGHT) : CW'(FIELD_WIDTH);
        half_s = size_s >>> 1;
        lens_in = ph_reg[0] ? cy_reg : cx_reg;
        lens_d = ph_reg[0] ? sum_reg[15:0] : hval;
        lens_q = (prod_reg < 0) ? -((-prod_reg) >>> 10) : (prod_reg >>> 10);
        lens_a = lens_q + 32'(half_s);
        case (state_reg)
            wrhf_pkg::ST_CLEAR: begin
                we = 1'b1; clr_both = 1'b1; waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) state_next = wrhf_pkg::ST_IDLE;
            end
            wrhf_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cx_next = in_x; cy_next = in_y;
                    sx_next = '0; sy_next = '0; acc_next = 1'b1; ph_next = '0;
                    case (s_tuser)
                        wrhf_pkg::MODE_DROP: begin
                            if (in_x >= CW'(FIELD_WIDTH) - r_s || in_x < r_s ||
                                in_y >= CW'(FIELD_HEIGHT) - r_s || in_y < r_s) begin
                                acc_next = 1'b0; state_next = wrhf_pkg::ST_OUT;
                            end else if (radius_reg == 6'd0) begin
                                state_next = wrhf_pkg::ST_OUT;
                            end else begin
                                px_next = in_x - r_s;
                                py_next = in_y - r_s;
                                state_next = wrhf_pkg::ST_DROP_RD;
                            end
                        end
                        wrhf_pkg::MODE_STEP: begin
                            px_next = '0; py_next = CW'(1); sum_next = '0;
                            state_next = wrhf_pkg::ST_STEP_RD;
                        end
                        wrhf_pkg::MODE_MAP: begin
                            if (in_x > CW'(FIELD_WIDTH - 1)) cx_next = CW'(FIELD_WIDTH - 1);
                            if (in_y > CW'(FIELD_HEIGHT - 1)) cy_next = CW'(FIELD_HEIGHT - 1);
                            state_next = wrhf_pkg::ST_MAP_RD;
                        end
                        default: state_next = wrhf_pkg::ST_OUT;
                    endcase
                end
            end
            wrhf_pkg::ST_DROP_RD: begin
                state_next = wrhf_pkg::ST_DROP_WR;
            end
            wrhf_pkg::ST_DROP_WR: begin
                we = (dsq < 0); wdata = rd_data + weight_reg;
                state_next = wrhf_pkg::ST_DROP_RD;
                if (py_reg == cy_reg + r_s - CW'(1)) begin
                    py_next = cy_reg - r_s; px_next = px_reg + CW'(1);
                    if (px_reg == cx_reg + r_s - CW'(1)) state_next = wrhf_pkg::ST_OUT;
                end else begin
                    py_next = py_reg + CW'(1);
                end
            end
            wrhf_pkg::ST_STEP_RD: begin
                // flat index neighbours: up, down, left, right, then old; read data is registered
                case (ph_reg)
                    3'd0: raddr = up_addr;
                    3'd1: raddr = dn_addr;
                    3'd2: raddr = lf_addr;
                    3'd3: raddr = rt_addr;
                    default: begin
                        raddr = cell_addr; rd_b = ~cur_b_reg;
                    end
                endcase
                if (ph_reg == 3'd1) sum_next = 19'(signed'(rd_data));
                else if (ph_reg != 3'd0) sum_next = sum_reg + 19'(signed'(rd_data));
                if (ph_reg == 3'd4) state_next = wrhf_pkg::ST_STEP_WR;
                else ph_next = ph_reg + 3'd1;
            end
            wrhf_pkg::ST_STEP_WR: begin
                we = 1'b1; wr_b = ~cur_b_reg;
                wdata = (damp_reg == 4'd0) ? 16'd0 : v16 - dmp;
                ph_next = '0;
                state_next = wrhf_pkg::ST_STEP_RD;
                if (px_reg == CW'(FIELD_WIDTH - 1)) begin
                    px_next = '0; py_next = py_reg + CW'(1);
                    if (py_reg == CW'(FIELD_HEIGHT - 2)) begin
                        cur_b_next = ~cur_b_reg; state_next = wrhf_pkg::ST_OUT;
                    end
                end else begin
                    px_next = px_reg + CW'(1);
                end
            end
            wrhf_pkg::ST_MAP_RD: begin
                raddr = {cy_reg[YW-1:0], cx_reg[XW-1:0]};
                state_next = wrhf_pkg::ST_MAP_MUL;
            end
            wrhf_pkg::ST_MAP_MUL: begin
                if (!ph_reg[0]) sum_next = 19'(hval);
                prod_next = 32'(lens_in - half_s) * 32'(lens_d);
                state_next = wrhf_pkg::ST_MAP_CLAMP;
            end
            wrhf_pkg::ST_MAP_CLAMP: begin
                if (lens_a >= 32'(size_s)) begin
                    if (ph_reg[0]) sy_next = 8'(size_s - CW'(1));
                    else sx_next = 8'(size_s - CW'(1));
                end else if (lens_a < 0) begin
                    if (ph_reg[0]) sy_next = '0; else sx_next = '0;
                end else begin
                    if (ph_reg[0]) sy_next = 8'(lens_a);
                    else sx_next = 8'(lens_a);
                end
                ph_next = 3'd1;
                state_next = ph_reg[0] ? wrhf_pkg::ST_OUT : wrhf_pkg::ST_MAP_MUL;
            end
            wrhf_pkg::ST_OUT: begin
                if (m_tready) state_next = wrhf_pkg::ST_IDLE;
            end
            default: state_next = wrhf_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: hdl/wrhf_checker.sv
// Port checker for the water ripple height field unit
`include "assert_macros.svh"
module wrhf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    `CHK_IMPL(no_overlap, aclk, aresetn, s_tready, !m_tvalid)
    `CHK_NEXT(out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_NEXT(busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `CHK_IMPL(pad_zero, aclk, aresetn, m_tvalid, m_tdata[23:17] == 7'd0)
endmodule

bind water_ripple_height_field_unit wrhf_checker u_wrhf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
